### sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication checked at every rising clock edge, disabled in reset
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication, disabled in reset
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

### sv/fpir_pkg.sv
// shared constants and types for the image resampler
// no dependencies
`default_nettype none
package fpir_pkg;
  localparam int MAX_SRC_WIDTH  = 1024;
  localparam int MAX_SRC_HEIGHT = 1024;
  localparam int FRAC_BITS      = 16;
  localparam int LEVEL_STEP     = 85;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_INV_SCALE_X = 3'd2,
    REG_INV_SCALE_Y = 3'd3,
    REG_WIN_X_START = 3'd4,
    REG_WIN_X_END   = 3'd5,
    REG_WIN_Y_START = 3'd6,
    REG_WIN_Y_END   = 3'd7
  } cfg_reg_t;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // configuration register file contents
  typedef struct packed {
    logic [10:0] src_width;
    logic [10:0] src_height;
    logic [23:0] inv_scale_x;
    logic [23:0] inv_scale_y;
    logic [12:0] win_x_start;
    logic [12:0] win_x_end;
    logic [12:0] win_y_start;
    logic [12:0] win_y_end;
  } cfg_t;

  // grey to 2-bit level
  function automatic logic [1:0] gray_level(input logic [7:0] g);
    logic [1:0] l;
    if (g >= 8'(3 * LEVEL_STEP)) l = 2'd3;
    else if (g >= 8'(2 * LEVEL_STEP)) l = 2'd2;
    else if (g >= 8'(LEVEL_STEP)) l = 2'd1;
    else l = 2'd0;
    return l;
  endfunction
endpackage
`default_nettype wire

### sv/fpir_addr.sv
// address stage: window test, fixed-point source mapping, clamping, mode select
// depends on fpir_pkg
`default_nettype none
module fpir_addr #(
  parameter int MAX_W = fpir_pkg::MAX_SRC_WIDTH,
  parameter int MAX_H = fpir_pkg::MAX_SRC_HEIGHT,
  parameter int FB    = fpir_pkg::FRAC_BITS,
  localparam int XW = $clog2(MAX_W),
  localparam int YW = $clog2(MAX_H)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire fpir_pkg::cfg_t cfg,
  input  wire logic          in_vld,
  input  wire logic          in_act,
  input  wire logic [11:0]   in_col,
  input  wire logic [11:0]   in_row,
  input  wire logic [7:0]    in_pix,
  // stage 2 outputs
  output logic               s2_vld_r,
  output logic               s2_load_r,
  output logic               s2_bil_r,
  output logic [XW-1:0]      s2_x0_r,
  output logic [XW-1:0]      s2_x1_r,
  output logic [YW-1:0]      s2_y0_r,
  output logic [YW-1:0]      s2_y1_r,
  output logic [FB-1:0]      s2_fx_r,
  output logic [FB-1:0]      s2_fy_r,
  output logic [7:0]         s2_pix_r,
  output logic [11:0]        s2_col_r,
  output logic [11:0]        s2_row_r
);
  localparam logic [23:0] FP_ONE = 24'(1) << FB;

  // stage 1: window test and multiply
  logic        s1_vld_r, s1_load_r, s1_bil_r;
  logic [35:0] s1_sx_r, s1_sy_r;
  logic [7:0]  s1_pix_r;
  logic [11:0] s1_col_r, s1_row_r;
  logic [12:0] w_eff_r, h_eff_r;
  logic        in_win, ld_ok;
  assign in_win = ({1'b0, in_col} >= cfg.win_x_start) && ({1'b0, in_col} < cfg.win_x_end) &&
                  ({1'b0, in_row} >= cfg.win_y_start) && ({1'b0, in_row} < cfg.win_y_end);
  assign ld_ok  = (32'(in_col) < 32'(MAX_W)) && (32'(in_row) < 32'(MAX_H));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld && ((in_act == fpir_pkg::ACT_LOAD) ? ld_ok : in_win);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_load_r <= (in_act == fpir_pkg::ACT_LOAD);
      s1_bil_r  <= (cfg.inv_scale_x < FP_ONE) && (cfg.inv_scale_y < FP_ONE);
      s1_sx_r   <= 36'(in_col) * 36'(cfg.inv_scale_x);
      s1_sy_r   <= 36'(in_row) * 36'(cfg.inv_scale_y);
      s1_pix_r  <= in_pix;
      s1_col_r  <= in_col;
      s1_row_r  <= in_row;
      // effective sizes
      if (cfg.src_width == '0) w_eff_r <= 13'd1;
      else if (32'(cfg.src_width) > 32'(MAX_W)) w_eff_r <= 13'(MAX_W);
      else w_eff_r <= 13'(cfg.src_width);
      if (cfg.src_height == '0) h_eff_r <= 13'd1;
      else if (32'(cfg.src_height) > 32'(MAX_H)) h_eff_r <= 13'(MAX_H);
      else h_eff_r <= 13'(cfg.src_height);
    end
  end

  // stage 2: clamp to the frame
  logic [35:0] ix, iy, ix1, iy1;
  logic [35:0] wl, hl;
  logic [35:0] cx0, cx1, cy0, cy1;
  assign ix  = s1_sx_r >> FB;
  assign iy  = s1_sy_r >> FB;
  assign ix1 = ix + 36'd1;
  assign iy1 = iy + 36'd1;
  assign wl  = 36'(w_eff_r) - 36'd1;
  assign hl  = 36'(h_eff_r) - 36'd1;
  assign cx0 = (ix  > wl) ? wl : ix;
  assign cx1 = (ix1 > wl) ? wl : ix1;
  assign cy0 = (iy  > hl) ? hl : iy;
  assign cy1 = (iy1 > hl) ? hl : iy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_load_r <= s1_load_r;
      s2_bil_r  <= s1_bil_r;
      if (s1_load_r) begin
        s2_x0_r <= s1_col_r[XW-1:0];
        s2_y0_r <= s1_row_r[YW-1:0];
      end else begin
        s2_x0_r <= cx0[XW-1:0];
        s2_y0_r <= cy0[YW-1:0];
      end
      s2_x1_r  <= cx1[XW-1:0];
      s2_y1_r  <= cy1[YW-1:0];
      s2_fx_r  <= s1_sx_r[FB-1:0];
      s2_fy_r  <= s1_sy_r[FB-1:0];
      s2_pix_r <= s1_pix_r;
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
    end
  end
endmodule
`default_nettype wire

### sv/fpir_store.sv
// frame store: four banks by column and row parity, one write and one read each
// depends on fpir_pkg
`default_nettype none
module fpir_store #(
  parameter int MAX_W = fpir_pkg::MAX_SRC_WIDTH,
  parameter int MAX_H = fpir_pkg::MAX_SRC_HEIGHT,
  localparam int XW = $clog2(MAX_W),
  localparam int YW = $clog2(MAX_H),
  localparam int BD = (MAX_W / 2) * (MAX_H / 2),
  localparam int AW = XW + YW - 2
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic         wr_en,
  input  wire logic [XW-1:0] wr_x,
  input  wire logic [YW-1:0] wr_y,
  input  wire logic [7:0]   wr_data,
  input  wire logic [XW-1:0] x0,
  input  wire logic [XW-1:0] x1,
  input  wire logic [YW-1:0] y0,
  input  wire logic [YW-1:0] y1,
  output logic [7:0]        p00_r,
  output logic [7:0]        p10_r,
  output logic [7:0]        p01_r,
  output logic [7:0]        p11_r
);
  // bank b = {row parity, col parity}; each neighbour lands in a distinct bank
  // when x1 is x0+1 and y1 is y0+1; when clamped x1 equals x0 (same bank) it
  // reads the same pixel, handled by a per-bank address choice
  logic [7:0]    q_r [4];
  logic [AW-1:0] raddr [4];
  logic [3:0]    bank_we;
  logic [AW-1:0] waddr;
  logic          s_x0_r, s_x1_r, s_y0_r, s_y1_r;

  assign waddr = {wr_y[YW-1:1], wr_x[XW-1:1]};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [XW-1:0] xs;
      logic [YW-1:0] ys;
      xs = (x0[0] == b[0]) ? x0 : x1;
      ys = (y0[0] == b[1]) ? y0 : y1;
      raddr[b]   = {ys[YW-1:1], xs[XW-1:1]};
      bank_we[b] = wr_en && (wr_x[0] == b[0]) && (wr_y[0] == b[1]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0] mem [BD];
    always_ff @(posedge clk) begin
      if (en && bank_we[g]) mem[waddr] <= wr_data;
      if (en) q_r[g] <= mem[raddr[g]];
    end
  end

  // remember which bank serves each neighbour
  always_ff @(posedge clk) begin
    if (en) begin
      s_x0_r <= x0[0];
      s_x1_r <= x1[0];
      s_y0_r <= y0[0];
      s_y1_r <= y1[0];
    end
  end

  assign p00_r = q_r[{s_y0_r, s_x0_r}];
  assign p10_r = q_r[{s_y0_r, s_x1_r}];
  assign p01_r = q_r[{s_y1_r, s_x0_r}];
  assign p11_r = q_r[{s_y1_r, s_x1_r}];
endmodule
`default_nettype wire

### sv/fpir_interp.sv
// interpolation stages: horizontal blend, vertical blend, level
// depends on fpir_pkg
`default_nettype none
module fpir_interp #(
  parameter int FB = fpir_pkg::FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic        bil,
  input  wire logic [FB-1:0] fx,
  input  wire logic [FB-1:0] fy,
  input  wire logic [7:0]  p00,
  input  wire logic [7:0]  p10,
  input  wire logic [7:0]  p01,
  input  wire logic [7:0]  p11,
  input  wire logic [11:0] col,
  input  wire logic [11:0] row,
  output logic             out_vld_r,
  output logic [7:0]       gray_r,
  output logic [1:0]       level_r,
  output logic [11:0]      col_r,
  output logic [11:0]      row_r
);
  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

  // horizontal stage
  logic          h_vld_r, h_bil_r;
  logic [7:0]    top_r, bot_r, near_r;
  logic [FB-1:0] h_fy_r;
  logic [11:0]   h_col_r, h_row_r;
  logic [FB+8:0] top_s, bot_s;
  assign top_s = (FB+9)'(p00) * (FB+9)'(ONE - (FB+1)'(fx)) + (FB+9)'(p10) * (FB+9)'(fx);
  assign bot_s = (FB+9)'(p01) * (FB+9)'(ONE - (FB+1)'(fx)) + (FB+9)'(p11) * (FB+9)'(fx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r   <= in_vld;
      out_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_r   <= top_s[FB+7:FB];
      bot_r   <= bot_s[FB+7:FB];
      near_r  <= p00;
      h_bil_r <= bil;
      h_fy_r  <= fy;
      h_col_r <= col;
      h_row_r <= row;
    end
  end

  // vertical stage
  logic [FB+8:0] v_s;
  logic [7:0]    g;
  assign v_s = (FB+9)'(top_r) * (FB+9)'(ONE - (FB+1)'(h_fy_r)) + (FB+9)'(bot_r) * (FB+9)'(h_fy_r);
  assign g   = h_bil_r ? v_s[FB+7:FB] : near_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gray_r  <= g;
      level_r <= fpir_pkg::gray_level(g);
      col_r   <= h_col_r;
      row_r   <= h_row_r;
    end
  end
endmodule
`default_nettype wire

### sv/fixed_point_image_resampler.sv
// Fixed-point greyscale resampler: load items fill a banked frame store, sample items
// return nearest-neighbour or bilinear grey values. One word per cycle is accepted while
// the pipeline advances; the pipeline has five register stages (multiply, clamp, bank
// read, horizontal blend, vertical blend into the output register). The whole
// pipeline advances whenever the output register is empty or being taken.
// depends on fpir_pkg, fpir_addr, fpir_store, fpir_interp
`default_nettype none
module fixed_point_image_resampler #(
  parameter int MAX_SRC_WIDTH  = fpir_pkg::MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = fpir_pkg::MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = fpir_pkg::FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // col[11:0], row[23:12], pixel[31:24]
  input  wire logic        in_tuser,  // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // gray, level, dst_col, dst_row, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);

  fpir_pkg::cfg_t cfg_r;
  logic en;
  logic s2_vld, s2_load, s2_bil;
  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [7:0] pix, p00, p10, p01, p11;
  logic [11:0] c2, r2;
  logic s3_vld_r, s3_bil_r;
  logic [FRAC_BITS-1:0] s3_fx_r, s3_fy_r;
  logic [11:0] s3_col_r, s3_row_r;
  logic o_vld;
  logic [7:0] gray;
  logic [1:0] lvl;
  logic [11:0] oc, orow;

  // the pipeline moves when the output register can take a word
  assign en         = !o_vld || out_tready;
  assign in_tready  = en;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = o_vld;
  assign out_tdata  = {6'd0, orow, oc, lvl, gray};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width   <= 11'd1024;
      cfg_r.src_height  <= 11'd1024;
      cfg_r.inv_scale_x <= 24'd65536;
      cfg_r.inv_scale_y <= 24'd65536;
      cfg_r.win_x_start <= 13'd0;
      cfg_r.win_x_end   <= 13'd1024;
      cfg_r.win_y_start <= 13'd0;
      cfg_r.win_y_end   <= 13'd1024;
    end else if (cfg_valid) begin
      case (fpir_pkg::cfg_reg_t'(cfg_index))
        fpir_pkg::REG_SRC_WIDTH:   cfg_r.src_width   <= cfg_data[10:0];
        fpir_pkg::REG_SRC_HEIGHT:  cfg_r.src_height  <= cfg_data[10:0];
        fpir_pkg::REG_INV_SCALE_X: cfg_r.inv_scale_x <= cfg_data;
        fpir_pkg::REG_INV_SCALE_Y: cfg_r.inv_scale_y <= cfg_data;
        fpir_pkg::REG_WIN_X_START: cfg_r.win_x_start <= cfg_data[12:0];
        fpir_pkg::REG_WIN_X_END:   cfg_r.win_x_end   <= cfg_data[12:0];
        fpir_pkg::REG_WIN_Y_START: cfg_r.win_y_start <= cfg_data[12:0];
        fpir_pkg::REG_WIN_Y_END:   cfg_r.win_y_end   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  fpir_addr #(.MAX_W(MAX_SRC_WIDTH), .MAX_H(MAX_SRC_HEIGHT), .FB(FRAC_BITS)) u_addr (
    .clk, .rst_n, .en, .cfg(cfg_r),
    .in_vld(in_tvalid), .in_act(in_tuser), .in_col(in_tdata[11:0]),
    .in_row(in_tdata[23:12]), .in_pix(in_tdata[31:24]),
    .s2_vld_r(s2_vld), .s2_load_r(s2_load), .s2_bil_r(s2_bil),
    .s2_x0_r(x0), .s2_x1_r(x1), .s2_y0_r(y0), .s2_y1_r(y1),
    .s2_fx_r(fx), .s2_fy_r(fy), .s2_pix_r(pix), .s2_col_r(c2), .s2_row_r(r2)
  );

  fpir_store #(.MAX_W(MAX_SRC_WIDTH), .MAX_H(MAX_SRC_HEIGHT)) u_store (
    .clk, .en, .wr_en(s2_vld && s2_load), .wr_x(x0), .wr_y(y0), .wr_data(pix),
    .x0, .x1, .y0, .y1, .p00_r(p00), .p10_r(p10), .p01_r(p01), .p11_r(p11)
  );

  // side band alongside the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld && !s2_load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_bil_r <= s2_bil;
      s3_fx_r  <= fx;
      s3_fy_r  <= fy;
      s3_col_r <= c2;
      s3_row_r <= r2;
    end
  end

  fpir_interp #(.FB(FRAC_BITS)) u_interp (
    .clk, .rst_n, .en, .in_vld(s3_vld_r), .bil(s3_bil_r), .fx(s3_fx_r), .fy(s3_fy_r),
    .p00, .p10, .p01, .p11, .col(s3_col_r), .row(s3_row_r),
    .out_vld_r(o_vld), .gray_r(gray), .level_r(lvl), .col_r(oc), .row_r(orow)
  );
endmodule
`default_nettype wire

### sv/fpir_checker.sv
// port-level checks for the resampler, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module fpir_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CHK_IMPL(a_rdy, clk, rst_n, !out_tvalid, in_tready)
  `CHK_IMPL(a_lvl, clk, rst_n, out_tvalid, out_tdata[9:8] == 2'(out_tdata[7:0] / 8'd85))
endmodule
bind fixed_point_image_resampler fpir_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire

### tb/fixed_point_image_resampler_tb.sv
// testbench for the fixed-point image resampler: loads small source frames, samples them
// under copy, bilinear and nearest-neighbour settings, and checks every result word
// depends on fpir_pkg and fixed_point_image_resampler
`default_nettype none

// tracks frame store contents and registers, predicts and checks resampled pixels
class resample_scoreboard;
  typedef struct {
    logic [7:0]  gray;
    logic [1:0]  level;
    logic [11:0] dst_col;
    logic [11:0] dst_row;
  } pixel_result_t;

  logic [7:0]      frame_px[int];
  pixel_result_t   pending_px[$];
  logic [10:0]     src_w, src_h;
  logic [23:0]     step_x, step_y;
  logic [12:0]     xs, xe, ys, ye;
  int              errors;

  function new();
    src_w = 11'd1024;
    src_h = 11'd1024;
    step_x = 24'd65536;
    step_y = 24'd65536;
    xs = '0;
    xe = 13'd1024;
    ys = '0;
    ye = 13'd1024;
    errors = 0;
  endfunction

  function void set_reg(fpir_pkg::cfg_reg_t idx, logic [23:0] v);
    case (idx)
      fpir_pkg::REG_SRC_WIDTH:   src_w = v[10:0];
      fpir_pkg::REG_SRC_HEIGHT:  src_h = v[10:0];
      fpir_pkg::REG_INV_SCALE_X: step_x = v;
      fpir_pkg::REG_INV_SCALE_Y: step_y = v;
      fpir_pkg::REG_WIN_X_START: xs = v[12:0];
      fpir_pkg::REG_WIN_X_END:   xe = v[12:0];
      fpir_pkg::REG_WIN_Y_START: ys = v[12:0];
      fpir_pkg::REG_WIN_Y_END:   ye = v[12:0];
      default: ;
    endcase
  endfunction

  function bit in_window(logic [11:0] col, logic [11:0] row);
    return col >= xs && col < xe && row >= ys && row < ye;
  endfunction

  function longint unsigned eff_size(longint unsigned v, longint unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function longint unsigned clamp_idx(longint unsigned i, longint unsigned n);
    return (i >= n) ? n - 1 : i;
  endfunction

  // store read; clears ok when the entry was never loaded
  function longint unsigned fetch(longint unsigned x, longint unsigned y, inout bit ok);
    int a;
    a = int'(y * fpir_pkg::MAX_SRC_WIDTH + x);
    if (!frame_px.exists(a)) begin
      ok = 0;
      return 0;
    end
    return frame_px[a];
  endfunction

  // grey value of a destination pixel, ok tells if every source read was loaded
  function logic [7:0] resample_gray(logic [11:0] col, logic [11:0] row, output bit ok);
    longint unsigned w, h, sx, sy, fx, fy, x0, x1, y0, y1, top, bot, one;
    ok = 1;
    one = 64'd1 << fpir_pkg::FRAC_BITS;
    w = eff_size(src_w, fpir_pkg::MAX_SRC_WIDTH);
    h = eff_size(src_h, fpir_pkg::MAX_SRC_HEIGHT);
    sx = longint'(col) * step_x;
    sy = longint'(row) * step_y;
    if (step_x < one && step_y < one) begin
      // bilinear blend of four clamped neighbours
      fx = sx & (one - 1);
      fy = sy & (one - 1);
      x0 = clamp_idx(sx >> fpir_pkg::FRAC_BITS, w);
      x1 = clamp_idx((sx >> fpir_pkg::FRAC_BITS) + 1, w);
      y0 = clamp_idx(sy >> fpir_pkg::FRAC_BITS, h);
      y1 = clamp_idx((sy >> fpir_pkg::FRAC_BITS) + 1, h);
      top = (fetch(x0, y0, ok) * (one - fx) + fetch(x1, y0, ok) * fx) >> fpir_pkg::FRAC_BITS;
      bot = (fetch(x0, y1, ok) * (one - fx) + fetch(x1, y1, ok) * fx) >> fpir_pkg::FRAC_BITS;
      return 8'(((top * (one - fy) + bot * fy) >> fpir_pkg::FRAC_BITS));
    end
    // copy and nearest neighbour truncate
    x0 = clamp_idx(sx >> fpir_pkg::FRAC_BITS, w);
    y0 = clamp_idx(sy >> fpir_pkg::FRAC_BITS, h);
    return 8'(fetch(x0, y0, ok));
  endfunction

  function bit readable(logic [11:0] col, logic [11:0] row);
    bit ok;
    logic [7:0] g;
    g = resample_gray(col, row, ok);
    return ok;
  endfunction

  function void note_input(logic action, logic [11:0] col, logic [11:0] row,
                           logic [7:0] pixel);
    pixel_result_t r;
    bit ok;
    if (action == fpir_pkg::ACT_LOAD) begin
      if (col < fpir_pkg::MAX_SRC_WIDTH && row < fpir_pkg::MAX_SRC_HEIGHT)
        frame_px[int'(row) * fpir_pkg::MAX_SRC_WIDTH + int'(col)] = pixel;
      return;
    end
    if (!in_window(col, row)) return;
    r.gray = resample_gray(col, row, ok);
    r.level = 2'((r.gray / 85) & 3);
    r.dst_col = col;
    r.dst_row = row;
    pending_px.push_back(r);
  endfunction

  function void check_result(logic [39:0] word);
    pixel_result_t e;
    if (pending_px.size() == 0) begin
      $error("result word with none expected: %h", word);
      errors++;
      return;
    end
    e = pending_px.pop_front();
    if (word[7:0] !== e.gray) begin
      $error("gray expected %0d actual %0d", e.gray, word[7:0]);
      errors++;
    end
    if (word[9:8] !== e.level) begin
      $error("level expected %0d actual %0d", e.level, word[9:8]);
      errors++;
    end
    if (word[21:10] !== e.dst_col) begin
      $error("dst_col expected %0d actual %0d", e.dst_col, word[21:10]);
      errors++;
    end
    if (word[33:22] !== e.dst_row) begin
      $error("dst_row expected %0d actual %0d", e.dst_row, word[33:22]);
      errors++;
    end
  endfunction
endclass

module fixed_point_image_resampler_tb;
  localparam int STALL_LIMIT = 5000;
  localparam int LATENCY     = 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // col[11:0], row[23:12], pixel[31:24]
  logic        in_tuser = 1'b0; // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;      // gray[7:0], level[9:8], dst_col[21:10], dst_row[33:22], pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  resample_scoreboard pixel_board = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic hold_off = 1'b0;
  int  quiet_cycles = 0;

  fixed_point_image_resampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver with random stalls and a long hold-off
  always @(posedge clk) begin
    out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // word monitor on both streams
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      pixel_board.note_input(in_tuser, in_tdata[11:0], in_tdata[23:12], in_tdata[31:24]);
    if (rst_n && out_tvalid && out_tready)
      pixel_board.check_result(out_tdata);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_word(logic action, logic [11:0] col, logic [11:0] row,
                           logic [7:0] pixel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= {pixel, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait out every pending pixel plus pipeline depth
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_board.pending_px.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_regs(logic [23:0] vals[8]);
    fpir_pkg::cfg_reg_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = fpir_pkg::cfg_reg_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      pixel_board.set_reg(idx, vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sample biased to the window, falls back to a stray load when nothing readable is found
  task automatic random_sample();
    logic [11:0] c, r;
    for (int t = 0; t < 30; t++) begin
      if ($urandom_range(9) == 0) begin
        c = 12'($urandom);
        r = 12'($urandom);
      end else begin
        c = 12'(pixel_board.xs + $urandom_range(0, 10));
        r = 12'(pixel_board.ys + $urandom_range(0, 10));
      end
      if (!pixel_board.in_window(c, r) || pixel_board.readable(c, r)) begin
        send_word(fpir_pkg::ACT_SAMPLE, c, r, 8'($urandom));
        return;
      end
    end
    send_word(fpir_pkg::ACT_LOAD, 12'($urandom), 12'($urandom), 8'($urandom));
  endtask

  function automatic logic [23:0] pick_step(int kind);
    case (kind)
      0: return 24'd65536;
      1: begin
        case ($urandom_range(4))
          0: return 24'd0;
          1: return 24'd1;
          2: return 24'd65535;
          default: return 24'($urandom_range(1, 65535));
        endcase
      end
      default: begin
        case ($urandom_range(3))
          0: return 24'hFFFFFF;
          1: return 24'd65536;
          default: return 24'($urandom_range(65536, 400000));
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [23:0] regs[8];
    int kind, lw, lh;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: copy mode at reset settings, corners, stray loads, window edge
    send_word(fpir_pkg::ACT_LOAD, 12'd0, 12'd0, 8'd0);
    send_word(fpir_pkg::ACT_LOAD, 12'd1023, 12'd1023, 8'd255);
    send_word(fpir_pkg::ACT_LOAD, 12'd1, 12'd0, 8'd170);
    send_word(fpir_pkg::ACT_LOAD, 12'd0, 12'd1, 8'd85);
    send_word(fpir_pkg::ACT_LOAD, 12'd1, 12'd1, 8'd84);
    send_word(fpir_pkg::ACT_LOAD, 12'd4095, 12'd4095, 8'd255);
    send_word(fpir_pkg::ACT_LOAD, 12'd1024, 12'd0, 8'd7);
    send_word(fpir_pkg::ACT_LOAD, 12'd0, 12'd1024, 8'd9);
    send_word(fpir_pkg::ACT_SAMPLE, 12'd0, 12'd0, 8'd0);
    send_word(fpir_pkg::ACT_SAMPLE, 12'd1023, 12'd1023, 8'd0);
    send_word(fpir_pkg::ACT_SAMPLE, 12'd1, 12'd0, 8'd0);
    send_word(fpir_pkg::ACT_SAMPLE, 12'd0, 12'd1, 8'd0);
    send_word(fpir_pkg::ACT_SAMPLE, 12'd1, 12'd1, 8'd0);
    send_word(fpir_pkg::ACT_SAMPLE, 12'd1024, 12'd0, 8'd0);
    send_word(fpir_pkg::ACT_SAMPLE, 12'd4095, 12'd4095, 8'd255);
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      // settings: copy, bilinear or nearest, with size and window extremes mixed in
      kind = ph % 3;
      case (ph % 8)
        0: regs[fpir_pkg::REG_SRC_WIDTH] = 24'd0;
        1: regs[fpir_pkg::REG_SRC_WIDTH] = 24'd2047;
        2: regs[fpir_pkg::REG_SRC_WIDTH] = 24'd1024;
        default: regs[fpir_pkg::REG_SRC_WIDTH] = 24'($urandom_range(1, 6));
      endcase
      case ((ph + 3) % 8)
        0: regs[fpir_pkg::REG_SRC_HEIGHT] = 24'd0;
        1: regs[fpir_pkg::REG_SRC_HEIGHT] = 24'hFFFFFF;
        default: regs[fpir_pkg::REG_SRC_HEIGHT] = 24'($urandom_range(1, 6));
      endcase
      regs[fpir_pkg::REG_INV_SCALE_X] = pick_step(kind);
      regs[fpir_pkg::REG_INV_SCALE_Y] = (kind == 2 && $urandom_range(1)) ?
                                        pick_step(1) : pick_step(kind);
      regs[fpir_pkg::REG_WIN_X_START] = 24'($urandom_range(0, 20));
      regs[fpir_pkg::REG_WIN_X_END] = regs[fpir_pkg::REG_WIN_X_START] +
                                      24'($urandom_range(1, 40));
      regs[fpir_pkg::REG_WIN_Y_START] = 24'($urandom_range(0, 20));
      regs[fpir_pkg::REG_WIN_Y_END] = regs[fpir_pkg::REG_WIN_Y_START] +
                                      24'($urandom_range(1, 40));
      if (ph == 4) begin
        regs[fpir_pkg::REG_WIN_X_START] = 24'd0;
        regs[fpir_pkg::REG_WIN_X_END] = 24'h1FFF;
        regs[fpir_pkg::REG_WIN_Y_START] = 24'd0;
        regs[fpir_pkg::REG_WIN_Y_END] = 24'd4096;
      end else if (ph == 9) begin
        regs[fpir_pkg::REG_WIN_X_START] = 24'h1FFF;
        regs[fpir_pkg::REG_WIN_X_END] = 24'd3;
      end else if (ph == 13) begin
        regs[fpir_pkg::REG_WIN_Y_START] = 24'hFFFFFF;
        regs[fpir_pkg::REG_WIN_Y_END] = 24'hFFE000;
      end
      write_regs(regs);

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase

      // long receiver hold-off while the sender keeps offering
      if (ph == 6) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (400) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end

      // load the part of the frame that samples reach
      lw = int'(pixel_board.eff_size(regs[fpir_pkg::REG_SRC_WIDTH][10:0],
                                     fpir_pkg::MAX_SRC_WIDTH));
      lh = int'(pixel_board.eff_size(regs[fpir_pkg::REG_SRC_HEIGHT][10:0],
                                     fpir_pkg::MAX_SRC_HEIGHT));
      lw = (lw > 6) ? 6 : lw;
      lh = (lh > 6) ? 6 : lh;
      for (int y = 0; y < lh; y++)
        for (int x = 0; x < lw; x++)
          send_word(fpir_pkg::ACT_LOAD, 12'(x), 12'(y), 8'($urandom));

      for (int n = 0; n < 36; n++) begin
        case ($urandom_range(19))
          0, 1: send_word(fpir_pkg::ACT_LOAD, 12'($urandom), 12'($urandom), 8'($urandom));
          2, 3, 4: send_word(fpir_pkg::ACT_LOAD, 12'($urandom_range(0, lw - 1)),
                             12'($urandom_range(0, lh - 1)), 8'($urandom));
          default: random_sample();
        endcase
      end
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (pixel_board.errors == 0 && pixel_board.pending_px.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
